// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked assertion that is also checked across reset
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/lcdns_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdns_pkg
// types and codes shared by the character lcd nibble sequencer
// ----------------------------------------------------------------------------
package lcdns_pkg;

    // request kinds
    localparam logic [2:0] REQ_INIT    = 3'd0;
    localparam logic [2:0] REQ_COMMAND = 3'd1;
    localparam logic [2:0] REQ_DATA    = 3'd2;
    localparam logic [2:0] REQ_CLEAR   = 3'd3;
    localparam logic [2:0] REQ_CURSOR  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_POWER_ON_WAIT  = 3'd0;
    localparam logic [2:0] CFG_ENABLE_PHASE   = 3'd1;
    localparam logic [2:0] CFG_COMMAND_SETTLE = 3'd2;
    localparam logic [2:0] CFG_DATA_SETTLE    = 3'd3;
    localparam logic [2:0] CFG_CLEAR_SETTLE   = 3'd4;

    // microcode store geometry and entry points
    localparam int UADDR_W = 6;
    localparam logic [UADDR_W-1:0] ENTRY_INIT = 6'd0;
    localparam logic [UADDR_W-1:0] ENTRY_BYTE = 6'd37;

    // nibble source
    typedef enum logic [1:0] {
        NIB_CONST = 2'd0,
        NIB_HIGH  = 2'd1,
        NIB_LOW   = 2'd2
    } nib_sel_t;

    // hold time source
    typedef enum logic {
        HOLD_PHASE = 1'b0,
        HOLD_POWER = 1'b1
    } hold_sel_t;

    // settle time added to the phase time
    typedef enum logic [2:0] {
        EXTRA_NONE  = 3'd0,
        EXTRA_FIVE  = 3'd1,
        EXTRA_ONE   = 3'd2,
        EXTRA_CMD   = 3'd3,
        EXTRA_CLEAR = 3'd4,
        EXTRA_REQ   = 3'd5
    } extra_sel_t;

    // sequencing of the step counter
    typedef enum logic {
        SEQ_NEXT = 1'b0,
        SEQ_END  = 1'b1
    } seq_t;

    // one control word of the program
    typedef struct packed {
        nib_sel_t   nib_sel;
        logic [3:0] nib_const;
        logic       en;
        hold_sel_t  hold_sel;
        extra_sel_t extra_sel;
        seq_t       seq;
    } ucode_t;

    // configuration register file
    typedef struct packed {
        logic [7:0] power_on_wait;
        logic [3:0] enable_phase;
        logic [3:0] command_settle;
        logic [3:0] data_settle;
        logic [3:0] clear_settle;
    } cfg_t;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic advance;
    } seq_ctl_t;

endpackage

// ----- rtl/lcdns_ucode_rom.sv -----
// ----------------------------------------------------------------------------
// lcdns_ucode_rom
// read-only program: one control word per emitted pin phase
// ----------------------------------------------------------------------------
module lcdns_ucode_rom (
    input  logic [lcdns_pkg::UADDR_W-1:0] addr,
    output lcdns_pkg::ucode_t             word
);
    import lcdns_pkg::*;

    function automatic ucode_t mk(nib_sel_t s, logic [3:0] c, logic en,
                                  extra_sel_t x, seq_t q);
        ucode_t w;
        w.nib_sel   = s;
        w.nib_const = c;
        w.en        = en;
        w.hold_sel  = HOLD_PHASE;
        w.extra_sel = x;
        w.seq       = q;
        return w;
    endfunction

    function automatic ucode_t mk_power(seq_t q);
        ucode_t w;
        w.nib_sel   = NIB_CONST;
        w.nib_const = 4'h0;
        w.en        = 1'b0;
        w.hold_sel  = HOLD_POWER;
        w.extra_sel = EXTRA_NONE;
        w.seq       = q;
        return w;
    endfunction

    // program: init routine at ENTRY_INIT, byte routine at ENTRY_BYTE
    always_comb begin
        case (addr)
            // power-on wait
            6'd0:  word = mk_power(SEQ_NEXT);
            // wake-up nibbles 0x3, 0x3, 0x3, then 0x2 for 4-bit mode
            6'd1:  word = mk(NIB_CONST, 4'h3, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd2:  word = mk(NIB_CONST, 4'h3, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd3:  word = mk(NIB_CONST, 4'h3, 1'b0, EXTRA_FIVE,  SEQ_NEXT);
            6'd4:  word = mk(NIB_CONST, 4'h3, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd5:  word = mk(NIB_CONST, 4'h3, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd6:  word = mk(NIB_CONST, 4'h3, 1'b0, EXTRA_ONE,   SEQ_NEXT);
            6'd7:  word = mk(NIB_CONST, 4'h3, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd8:  word = mk(NIB_CONST, 4'h3, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd9:  word = mk(NIB_CONST, 4'h3, 1'b0, EXTRA_ONE,   SEQ_NEXT);
            6'd10: word = mk(NIB_CONST, 4'h2, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd11: word = mk(NIB_CONST, 4'h2, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd12: word = mk(NIB_CONST, 4'h2, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            // function set 0x28
            6'd13: word = mk(NIB_CONST, 4'h2, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd14: word = mk(NIB_CONST, 4'h2, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd15: word = mk(NIB_CONST, 4'h2, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd16: word = mk(NIB_CONST, 4'h8, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd17: word = mk(NIB_CONST, 4'h8, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd18: word = mk(NIB_CONST, 4'h8, 1'b0, EXTRA_CMD,   SEQ_NEXT);
            // display on 0x0C
            6'd19: word = mk(NIB_CONST, 4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd20: word = mk(NIB_CONST, 4'h0, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd21: word = mk(NIB_CONST, 4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd22: word = mk(NIB_CONST, 4'hC, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd23: word = mk(NIB_CONST, 4'hC, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd24: word = mk(NIB_CONST, 4'hC, 1'b0, EXTRA_CMD,   SEQ_NEXT);
            // clear display 0x01
            6'd25: word = mk(NIB_CONST, 4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd26: word = mk(NIB_CONST, 4'h0, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd27: word = mk(NIB_CONST, 4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd28: word = mk(NIB_CONST, 4'h1, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd29: word = mk(NIB_CONST, 4'h1, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd30: word = mk(NIB_CONST, 4'h1, 1'b0, EXTRA_CLEAR, SEQ_NEXT);
            // entry mode 0x06
            6'd31: word = mk(NIB_CONST, 4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd32: word = mk(NIB_CONST, 4'h0, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd33: word = mk(NIB_CONST, 4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd34: word = mk(NIB_CONST, 4'h6, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd35: word = mk(NIB_CONST, 4'h6, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd36: word = mk(NIB_CONST, 4'h6, 1'b0, EXTRA_CMD,   SEQ_END);
            // generic byte from the request context
            6'd37: word = mk(NIB_HIGH,  4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd38: word = mk(NIB_HIGH,  4'h0, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd39: word = mk(NIB_HIGH,  4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd40: word = mk(NIB_LOW,   4'h0, 1'b0, EXTRA_NONE,  SEQ_NEXT);
            6'd41: word = mk(NIB_LOW,   4'h0, 1'b1, EXTRA_NONE,  SEQ_NEXT);
            6'd42: word = mk(NIB_LOW,   4'h0, 1'b0, EXTRA_REQ,   SEQ_END);
            // unused addresses end the routine
            default: word = mk_power(SEQ_END);
        endcase
    end

endmodule

// ----- rtl/lcdns_sequencer.sv -----
// ----------------------------------------------------------------------------
// lcdns_sequencer
// step counter, request dispatch and output valid control
// ----------------------------------------------------------------------------
module lcdns_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_req_type,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  lcdns_pkg::ucode_t             uword,
    output logic [lcdns_pkg::UADDR_W-1:0] pc,
    output lcdns_pkg::seq_ctl_t           ctl
);
    import lcdns_pkg::*;

    logic               busy_reg, busy_next;
    logic [UADDR_W-1:0] pc_reg, pc_next;
    logic               out_valid_reg, out_valid_next;
    logic               req_ok;

    assign s_ready = !busy_reg;
    assign m_valid = out_valid_reg;
    assign pc      = pc_reg;
    assign req_ok  = (s_req_type inside {[REQ_INIT:REQ_CURSOR]});

    // transfer strobes: load context on accept, step when output slot is free
    assign ctl.load    = s_valid && !busy_reg;
    assign ctl.advance = busy_reg && (!out_valid_reg || m_ready);

    // dispatch and step
    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (ctl.load && req_ok) begin
            busy_next = 1'b1;
            pc_next   = (s_req_type == REQ_INIT) ? ENTRY_INIT : ENTRY_BYTE;
        end else if (ctl.advance) begin
            if (uword.seq == SEQ_END) begin
                busy_next = 1'b0;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    // output slot occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pc_reg        <= ENTRY_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/lcdns_datapath.sv -----
// ----------------------------------------------------------------------------
// lcdns_datapath
// request context and phase formation into the output register
// ----------------------------------------------------------------------------
module lcdns_datapath (
    input  logic                aclk,
    input  lcdns_pkg::cfg_t     cfg,
    input  lcdns_pkg::seq_ctl_t ctl,
    input  lcdns_pkg::ucode_t   uword,
    input  logic [2:0]          s_req_type,
    input  logic [7:0]          s_byte_value,
    input  logic [5:0]          s_column,
    input  logic [1:0]          s_line_index,
    output logic                m_reg_select,
    output logic [3:0]          m_data_nibble,
    output logic                m_enable_level,
    output logic [8:0]          m_hold_ms,
    output logic                m_last_phase
);
    import lcdns_pkg::*;

    localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM     = 8'h80;

    logic       rs_reg;
    logic [7:0] byte_reg;
    logic [4:0] extra_reg;

    logic       rs_next;
    logic [7:0] byte_next;
    logic [4:0] extra_next;
    logic [7:0] row_base;
    logic [4:0] clear_sum;

    logic [3:0] nib;
    logic [4:0] extra;
    logic [8:0] hold;

    assign clear_sum = {1'b0, cfg.command_settle} + {1'b0, cfg.clear_settle};

    // ddram address of the first column of each row
    always_comb begin
        case (s_line_index)
            2'd0:    row_base = 8'h00;
            2'd1:    row_base = 8'h40;
            2'd2:    row_base = 8'h14;
            default: row_base = 8'h54;
        endcase
    end

    // request context: rs level, byte to send, settle after the byte
    always_comb begin
        rs_next    = (s_req_type == REQ_DATA);
        byte_next  = s_byte_value;
        extra_next = {1'b0, cfg.command_settle};
        case (s_req_type)
            REQ_DATA: begin
                extra_next = {1'b0, cfg.data_settle};
            end
            REQ_CLEAR: begin
                byte_next  = CMD_CLEAR_DISPLAY;
                extra_next = clear_sum;
            end
            REQ_CURSOR: begin
                byte_next = CMD_SET_DDRAM | ({2'b00, s_column} + row_base);
            end
            default: begin
                byte_next = s_byte_value;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rs_reg    <= rs_next;
            byte_reg  <= byte_next;
            extra_reg <= extra_next;
        end
    end

    // nibble source
    always_comb begin
        case (uword.nib_sel)
            NIB_HIGH: nib = byte_reg[7:4];
            NIB_LOW:  nib = byte_reg[3:0];
            default:  nib = uword.nib_const;
        endcase
    end

    // settle time folded into the hold
    always_comb begin
        case (uword.extra_sel)
            EXTRA_FIVE:  extra = 5'd5;
            EXTRA_ONE:   extra = 5'd1;
            EXTRA_CMD:   extra = {1'b0, cfg.command_settle};
            EXTRA_CLEAR: extra = clear_sum;
            EXTRA_REQ:   extra = extra_reg;
            default:     extra = 5'd0;
        endcase
    end

    assign hold = (uword.hold_sel == HOLD_POWER) ? {1'b0, cfg.power_on_wait}
                : ({5'd0, cfg.enable_phase} + {4'd0, extra});

    // output register, loaded on each step
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            m_reg_select   <= rs_reg;
            m_data_nibble  <= nib;
            m_enable_level <= uword.en;
            m_hold_ms      <= hold;
            m_last_phase   <= (uword.seq == SEQ_END);
        end
    end

endmodule

// ----- rtl/char_lcd_nibble_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top
// hd44780-style 4-bit bus sequencer: requests in, timed pin phases out
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request per transfer (init, command, data, clear,
//   set cursor). m_* channel gives one pin phase per transfer: rs, d4..d7,
//   en and a hold time in ms; last_phase marks the final phase of a request.
//   cfg_we/cfg_index/cfg_wdata write the timing registers; write them only
//   while the block is idle. Indexes 5 to 7 are ignored.
// Timing:
//   The step counter walks one microcode word per cycle while the output
//   register is free or being taken, one word per phase. Init gives 37
//   phases, the other requests 6 each. An accept loads the busy flag and
//   step counter; the first phase then steps into the output register.
//   Request kinds 5 to 7 are accepted and give no phase.
//   s_ready is low from the accept until the last phase is in the output
//   register, so the next request can be taken while that phase waits.
// Reset and stall:
//   Reset restores the default timing and drops any request in progress.
//   A stalled receiver holds the output register and freezes the counter.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [7:0] s_byte_value,
    input  logic [5:0] s_column,
    input  logic [1:0] s_line_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_reg_select,
    output logic [3:0] m_data_nibble,
    output logic       m_enable_level,
    output logic [8:0] m_hold_ms,
    output logic       m_last_phase
);
    import lcdns_pkg::*;

    cfg_t               cfg_reg;
    ucode_t             uword;
    logic [UADDR_W-1:0] pc;
    seq_ctl_t           ctl;

    // timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_on_wait  <= 8'd50;
            cfg_reg.enable_phase   <= 4'd1;
            cfg_reg.command_settle <= 4'd2;
            cfg_reg.data_settle    <= 4'd1;
            cfg_reg.clear_settle   <= 4'd2;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_POWER_ON_WAIT:  cfg_reg.power_on_wait  <= cfg_wdata;
                CFG_ENABLE_PHASE:   cfg_reg.enable_phase   <= cfg_wdata[3:0];
                CFG_COMMAND_SETTLE: cfg_reg.command_settle <= cfg_wdata[3:0];
                CFG_DATA_SETTLE:    cfg_reg.data_settle    <= cfg_wdata[3:0];
                CFG_CLEAR_SETTLE:   cfg_reg.clear_settle   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // program store
    lcdns_ucode_rom u_rom (
        .addr (pc),
        .word (uword)
    );

    // step counter and handshake control
    lcdns_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .uword      (uword),
        .pc         (pc),
        .ctl        (ctl)
    );

    // context and phase datapath
    lcdns_datapath u_dp (
        .aclk           (aclk),
        .cfg            (cfg_reg),
        .ctl            (ctl),
        .uword          (uword),
        .s_req_type     (s_req_type),
        .s_byte_value   (s_byte_value),
        .s_column       (s_column),
        .s_line_index   (s_line_index),
        .m_reg_select   (m_reg_select),
        .m_data_nibble  (m_data_nibble),
        .m_enable_level (m_enable_level),
        .m_hold_ms      (m_hold_ms),
        .m_last_phase   (m_last_phase)
    );

endmodule

// ----- rtl/lcdns_checker.sv -----
// ----------------------------------------------------------------------------
// lcdns_checker
// port-level checks of the nibble sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdns_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_req_type,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_reg_select,
    input logic [3:0] m_data_nibble,
    input logic       m_enable_level,
    input logic [8:0] m_hold_ms,
    input logic       m_last_phase
);
    import lcdns_pkg::*;

    logic req_ok;
    assign req_ok = (s_req_type == REQ_INIT) || (s_req_type == REQ_COMMAND) ||
                    (s_req_type == REQ_DATA) || (s_req_type == REQ_CLEAR) ||
                    (s_req_type == REQ_CURSOR);

    // a stalled phase keeps its pins
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data_nibble) && $stable(m_hold_ms) && $stable(m_enable_level) && $stable(m_reg_select) && $stable(m_last_phase), "stalled phase changed")

    // a known request blocks the input while its phases run
    `ASSERT_CLK(a_busy_after_req, s_valid && s_ready && req_ok |=> !s_ready, "input not blocked after request")

    // a request always ends with enable low
    `ASSERT_CLK(a_last_en_low, m_valid && m_last_phase |-> !m_enable_level, "last phase with enable high")

    // enable high phases carry no settle time
    `ASSERT_CLK(a_en_high_hold, m_valid && m_enable_level |-> m_hold_ms < 9'd16, "enable high hold too long")

    // no phase right after reset
    `ASSERT_CLK_RST(a_reset_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")

endmodule

bind char_lcd_nibble_sequencer_top lcdns_checker u_checker (.*);

// ----- verif/lcd_phase_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_phase_checker
// watches both channels of the lcd nibble sequencer and checks every phase
// ----------------------------------------------------------------------------
// Follows the timing register writes, expands each accepted request into
// the pin phases it must produce, and compares each phase transfer on the
// m_ side against the oldest outstanding phase. Hands the failure count,
// the number of outstanding phases and the number of checked phases to
// the testbench top.
// ----------------------------------------------------------------------------
module lcd_phase_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [7:0] s_byte_value,
    input  logic [5:0] s_column,
    input  logic [1:0] s_line_index,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_reg_select,
    input  logic [3:0] m_data_nibble,
    input  logic       m_enable_level,
    input  logic [8:0] m_hold_ms,
    input  logic       m_last_phase,
    output int         fail_count,
    output int         pending_count,
    output int         phase_count
);
    import lcdns_pkg::*;

    localparam int MAX_REPORTS = 10;

    // pin levels
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;
    localparam logic EN_LOW     = 1'b0;
    localparam logic EN_HIGH    = 1'b1;

    // wake-up nibbles and fixed waits of the init sequence
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;
    localparam logic [3:0] NIB_POWER_ON  = 4'h0;
    localparam logic [8:0] WAIT_FIRST    = 9'd5;
    localparam logic [8:0] WAIT_NEXT     = 9'd1;
    localparam logic [8:0] WAIT_NONE     = 9'd0;

    // controller commands
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] LCD_CLEAR        = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;

    // ddram start address of each row
    localparam logic [7:0] ROW0_BASE = 8'h00;
    localparam logic [7:0] ROW1_BASE = 8'h40;
    localparam logic [7:0] ROW2_BASE = 8'h14;
    localparam logic [7:0] ROW3_BASE = 8'h54;

    localparam cfg_t TIMING_DEFAULT = {8'd50, 4'd1, 4'd2, 4'd1, 4'd2};

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic       en;
        logic [8:0] hold;
        logic       last;
    } lcd_phase_t;

    lcd_phase_t phase_q[$];
    lcd_phase_t want;
    cfg_t       timing;
    int         errors;
    int         checked;

    task automatic push_phase(input logic rs, input logic [3:0] nib, input logic en,
                              input logic [8:0] hold);
        lcd_phase_t ph;
        ph.rs     = rs;
        ph.nibble = nib;
        ph.en     = en;
        ph.hold   = hold;
        ph.last   = 1'b0;
        phase_q.push_back(ph);
    endtask

    // one nibble is EN low, high, low; the settle time rides on the final low
    task automatic push_nibble(input logic rs, input logic [3:0] nib,
                               input logic [8:0] settle);
        logic [8:0] t;
        t = 9'(timing.enable_phase);
        push_phase(rs, nib, EN_LOW, t);
        push_phase(rs, nib, EN_HIGH, t);
        push_phase(rs, nib, EN_LOW, t + settle);
    endtask

    task automatic push_byte(input logic rs, input logic [7:0] value,
                             input logic [8:0] settle);
        push_nibble(rs, value[7:4], WAIT_NONE);
        push_nibble(rs, value[3:0], settle);
    endtask

    task automatic predict_phases(input logic [2:0] kind, input logic [7:0] value,
                                  input logic [5:0] col, input logic [1:0] row);
        logic [8:0] cmd_wait;
        logic [8:0] clr_wait;
        logic [7:0] row_base;
        int         before_n;
        lcd_phase_t tail;
        cmd_wait = 9'(timing.command_settle);
        clr_wait = 9'(timing.command_settle) + 9'(timing.clear_settle);
        before_n = phase_q.size();
        case (kind)
            REQ_INIT: begin
                push_phase(RS_COMMAND, NIB_POWER_ON, EN_LOW, 9'(timing.power_on_wait));
                push_nibble(RS_COMMAND, NIB_WAKE, WAIT_FIRST);
                push_nibble(RS_COMMAND, NIB_WAKE, WAIT_NEXT);
                push_nibble(RS_COMMAND, NIB_WAKE, WAIT_NEXT);
                push_nibble(RS_COMMAND, NIB_FOUR_BIT, WAIT_NONE);
                push_byte(RS_COMMAND, LCD_FUNCTION_SET, cmd_wait);
                push_byte(RS_COMMAND, LCD_DISPLAY_ON, cmd_wait);
                push_byte(RS_COMMAND, LCD_CLEAR, clr_wait);
                push_byte(RS_COMMAND, LCD_ENTRY_MODE, cmd_wait);
            end
            REQ_COMMAND: push_byte(RS_COMMAND, value, cmd_wait);
            REQ_DATA:    push_byte(RS_DATA, value, 9'(timing.data_settle));
            REQ_CLEAR:   push_byte(RS_COMMAND, LCD_CLEAR, clr_wait);
            REQ_CURSOR: begin
                case (row)
                    2'd0:    row_base = ROW0_BASE;
                    2'd1:    row_base = ROW1_BASE;
                    2'd2:    row_base = ROW2_BASE;
                    default: row_base = ROW3_BASE;
                endcase
                // address wraps at 8 bits, columns past 39 included
                push_byte(RS_COMMAND, LCD_SET_DDRAM | ({2'b00, col} + row_base), cmd_wait);
            end
            default: ;
        endcase
        // flag the final phase of the request
        if (phase_q.size() > before_n) begin
            tail = phase_q.pop_back();
            tail.last = 1'b1;
            phase_q.push_back(tail);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            timing = TIMING_DEFAULT;
            phase_q.delete();
            errors  = 0;
            checked = 0;
        end else begin
            // timing register writes, unused indexes change nothing
            if (cfg_we) begin
                case (cfg_index)
                    CFG_POWER_ON_WAIT:  timing.power_on_wait  = cfg_wdata;
                    CFG_ENABLE_PHASE:   timing.enable_phase   = cfg_wdata[3:0];
                    CFG_COMMAND_SETTLE: timing.command_settle = cfg_wdata[3:0];
                    CFG_DATA_SETTLE:    timing.data_settle    = cfg_wdata[3:0];
                    CFG_CLEAR_SETTLE:   timing.clear_settle   = cfg_wdata[3:0];
                    default: ;
                endcase
            end

            // phase transfer against the oldest outstanding phase
            if (m_valid && m_ready) begin
                if (phase_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected phase rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                 $time, m_reg_select, m_data_nibble, m_enable_level,
                                 m_hold_ms, m_last_phase);
                end else begin
                    want = phase_q.pop_front();
                    checked++;
                    if (m_reg_select !== want.rs || m_data_nibble !== want.nibble ||
                        m_enable_level !== want.en || m_hold_ms !== want.hold ||
                        m_last_phase !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: phase %0d mismatch", $time, checked);
                            $display("    expected rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                     want.rs, want.nibble, want.en, want.hold, want.last);
                            $display("    actual   rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                     m_reg_select, m_data_nibble, m_enable_level,
                                     m_hold_ms, m_last_phase);
                        end
                    end
                end
            end

            // request transfer
            if (s_valid && s_ready)
                predict_phases(s_req_type, s_byte_value, s_column, s_line_index);
        end
        fail_count    <= errors;
        pending_count <= phase_q.size();
        phase_count   <= checked;
    end

endmodule

// ----- verif/tb_char_lcd_nibble_sequencer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer_top
// request stimulus and verdict for the character lcd nibble sequencer
// ----------------------------------------------------------------------------
// Drives directed requests (every request kind, byte extremes, every row,
// cursor columns past the display, ignored kinds) and then random phases of
// requests under changing timing settings, including all-zero and all-max.
// Both channels idle at random. The checker beside the block predicts and
// compares each pin phase; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer_top;
    import lcdns_pkg::*;

    // longest quiet stretch of a correct run is the longest source gap or
    // receiver stall plus the pipeline; this is many times that
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 40;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 34;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_req_type;
    logic [7:0] s_byte_value;
    logic [5:0] s_column;
    logic [1:0] s_line_index;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_reg_select;
    logic [3:0] m_data_nibble;
    logic       m_enable_level;
    logic [8:0] m_hold_ms;
    logic       m_last_phase;

    int fail_count;
    int pending_count;
    int phase_count;

    int src_idle_pct  = 20;
    int sink_idle_pct = 30;
    int sink_stall;
    int idle_cycles   = 0;
    int n_requests    = 0;
    int n_inits       = 0;
    int n_ignored     = 0;
    int n_settings    = 0;

    char_lcd_nibble_sequencer_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_byte_value   (s_byte_value),
        .s_column       (s_column),
        .s_line_index   (s_line_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reg_select   (m_reg_select),
        .m_data_nibble  (m_data_nibble),
        .m_enable_level (m_enable_level),
        .m_hold_ms      (m_hold_ms),
        .m_last_phase   (m_last_phase)
    );

    lcd_phase_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_byte_value   (s_byte_value),
        .s_column       (s_column),
        .s_line_index   (s_line_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reg_select   (m_reg_select),
        .m_data_nibble  (m_data_nibble),
        .m_enable_level (m_enable_level),
        .m_hold_ms      (m_hold_ms),
        .m_last_phase   (m_last_phase),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .phase_count    (phase_count)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 4);
    endfunction

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_stall = 0;
        end else if (sink_stall > 0) begin
            m_ready <= 1'b0;
            sink_stall--;
        end else begin
            sink_stall = pick_gap(sink_idle_pct);
            m_ready <= (sink_stall == 0);
            if (sink_stall > 0)
                sink_stall--;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d phases outstanding",
                     idle_cycles, pending_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // drop valid and wait until no phase has been outstanding for a while
    task automatic wait_idle(input int quiet);
        int calm;
        calm = 0;
        s_valid <= 1'b0;
        while (calm < quiet) begin
            @(posedge aclk);
            if (pending_count != 0)
                calm = 0;
            else
                calm++;
        end
    endtask

    // one request transfer; valid stays up when the next one follows at once
    task automatic send_request(input logic [2:0] kind, input logic [7:0] value,
                                input logic [5:0] col, input logic [1:0] row);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_byte_value <= value;
        s_column     <= col;
        s_line_index <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (kind > REQ_CURSOR)
            n_ignored++;
        else
            n_requests++;
        if (kind == REQ_INIT)
            n_inits++;
    endtask

    // write all timing registers while idle, plus one write to an unused index
    task automatic set_timing(input logic [7:0] pow, input logic [3:0] en, cmd, dat, clr);
        wait_idle(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POWER_ON_WAIT;
        cfg_wdata <= pow;
        @(posedge aclk);
        cfg_index <= CFG_ENABLE_PHASE;
        cfg_wdata <= {4'($urandom), en};
        @(posedge aclk);
        cfg_index <= CFG_COMMAND_SETTLE;
        cfg_wdata <= {4'($urandom), cmd};
        @(posedge aclk);
        cfg_index <= CFG_DATA_SETTLE;
        cfg_wdata <= {4'($urandom), dat};
        @(posedge aclk);
        cfg_index <= CFG_CLEAR_SETTLE;
        cfg_wdata <= {4'($urandom), clr};
        @(posedge aclk);
        cfg_index <= CFG_CLEAR_SETTLE + 3'($urandom_range(1, 3));
        cfg_wdata <= 8'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // random request, weighted toward the common kinds
    task automatic send_random_request();
        int         pick;
        logic [2:0] kind;
        logic [5:0] col;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            kind = REQ_INIT;
        else if (pick < 30)
            kind = REQ_COMMAND;
        else if (pick < 62)
            kind = REQ_DATA;
        else if (pick < 72)
            kind = REQ_CLEAR;
        else if (pick < 94)
            kind = REQ_CURSOR;
        else
            kind = REQ_CURSOR + 3'($urandom_range(1, 3));
        // mostly visible columns, some past the end of the line
        if ($urandom_range(0, 4) == 0)
            col = 6'($urandom);
        else
            col = 6'($urandom_range(0, 39));
        send_request(kind, 8'($urandom), col, 2'($urandom));
    endtask

    initial begin
        int k;
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_POWER_ON_WAIT;
        cfg_wdata    <= 8'd0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_INIT;
        s_byte_value <= 8'd0;
        s_column     <= 6'd0;
        s_line_index <= 2'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default timing, every kind and the field extremes
        send_request(REQ_INIT, 8'($urandom), 6'($urandom), 2'($urandom));
        send_request(REQ_COMMAND, 8'h00, 6'($urandom), 2'($urandom));
        send_request(REQ_COMMAND, 8'hFF, 6'($urandom), 2'($urandom));
        send_request(REQ_DATA, 8'h00, 6'($urandom), 2'($urandom));
        send_request(REQ_DATA, 8'hFF, 6'($urandom), 2'($urandom));
        send_request(REQ_DATA, 8'hA5, 6'($urandom), 2'($urandom));
        send_request(REQ_DATA, 8'h5A, 6'($urandom), 2'($urandom));
        send_request(REQ_CLEAR, 8'($urandom), 6'($urandom), 2'($urandom));
        // sender holds off until every phase has drained
        wait_idle(1);
        for (k = 0; k < 4; k++)
            send_request(REQ_CURSOR, 8'($urandom), 6'd0, 2'(k));
        send_request(REQ_CURSOR, 8'($urandom), 6'd39, 2'd3);
        send_request(REQ_CURSOR, 8'($urandom), 6'd63, 2'd3);
        send_request(REQ_CURSOR, 8'($urandom), 6'd63, 2'd1);
        // unknown kinds give no phase
        for (k = 1; k <= 3; k++)
            send_request(REQ_CURSOR + 3'(k), 8'($urandom), 6'($urandom), 2'($urandom));

        // directed: longest timing
        set_timing(8'hFF, 4'hF, 4'hF, 4'hF, 4'hF);
        send_request(REQ_INIT, 8'($urandom), 6'($urandom), 2'($urandom));
        send_request(REQ_CLEAR, 8'($urandom), 6'($urandom), 2'($urandom));
        send_request(REQ_DATA, 8'h41, 6'($urandom), 2'($urandom));
        send_request(REQ_CURSOR, 8'($urandom), 6'd20, 2'd2);

        // directed: zero timing
        set_timing(8'h00, 4'h0, 4'h0, 4'h0, 4'h0);
        send_request(REQ_INIT, 8'($urandom), 6'($urandom), 2'($urandom));
        send_request(REQ_COMMAND, 8'h0C, 6'($urandom), 2'($urandom));
        send_request(REQ_DATA, 8'h7E, 6'($urandom), 2'($urandom));

        // random phases, each with its own timing and idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       set_timing(8'hFF, 4'hF, 4'hF, 4'hF, 4'hF);
                1:       set_timing(8'h00, 4'h0, 4'h0, 4'h0, 4'h0);
                default: set_timing(8'($urandom), 4'($urandom), 4'($urandom),
                                    4'($urandom), 4'($urandom));
            endcase
            // first phase runs without idling on either side
            if (ph == 0) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = 10 * $urandom_range(0, 7);
                sink_idle_pct = 10 * $urandom_range(0, 7);
            end
            k = 0;
            while (k < PHASE_ITEMS) begin
                send_random_request();
                if (s_req_type <= REQ_CURSOR)
                    k++;
                if ($urandom_range(0, 29) == 0)
                    wait_idle(1);
            end
        end

        // drain and let the block go quiet
        sink_idle_pct = 20;
        wait_idle(END_CYCLES);

        $display("covered %0d requests (%0d init, %0d ignored kinds) over %0d timing settings",
                 n_requests, n_inits, n_ignored, n_settings);
        $display("checked %0d pin phases, %0d failures, %0d outstanding",
                 phase_count, fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lcdns_pkg.sv
rtl/lcdns_ucode_rom.sv
rtl/lcdns_sequencer.sv
rtl/lcdns_datapath.sv
rtl/char_lcd_nibble_sequencer_top.sv
rtl/lcdns_checker.sv
verif/lcd_phase_checker.sv
verif/tb_char_lcd_nibble_sequencer_top.sv
